FILE: rtl/core/srcmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor compensation package
// Shared item types, calibration layout, constants and 32-bit helpers.
// ----------------------------------------------------------------------------
package srcmp_pkg;

  localparam int unsigned DivW = 32;

  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] RawPFull    = 32'd1048576;
  localparam logic [31:0] PScale      = 32'd3125;
  localparam logic [31:0] PHalfRange  = 32'h8000_0000;
  localparam logic [31:0] HTempOffset = 32'd76800;
  localparam logic [31:0] HConstA     = 32'd2097152;
  localparam logic [31:0] HClamp      = 32'd419430400;
  localparam logic [31:0] C32768      = 32'd32768;
  localparam logic [31:0] C16384      = 32'd16384;
  localparam logic [31:0] C8192       = 32'd8192;
  localparam logic [31:0] C128        = 32'd128;
  localparam logic [31:0] C5          = 32'd5;

  typedef enum logic [2:0] {
    RegTemp   = 3'd0,
    RegPressL = 3'd1,
    RegPressH = 3'd2,
    RegP9Hum  = 3'd3,
    RegHumH   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_q10;
    logic               divide_error;
  } out_item_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [47:0] p9_hum;
    logic [39:0] hum_hi;
  } calib_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [16:0] hum;
    logic        err;
    logic        dbl;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] dividend;
    logic [31:0] divisor;
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] quotient;
    side_t       side;
  } div_rsp_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] f);
    return {{16{f[15]}}, f};
  endfunction

  function automatic logic [31:0] ux16(input logic [15:0] f);
    return {16'b0, f};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] f);
    return {{24{f[7]}}, f};
  endfunction

  function automatic logic [31:0] ux8(input logic [7:0] f);
    return {24'b0, f};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/srcmp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibration register file
// APB-style write and read access to the five packed coefficient registers.
// ----------------------------------------------------------------------------
module srcmp_cfg import srcmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output calib_t      cal_o
);

  calib_t   cal_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign pready = 1'b1;
  assign cal_o  = cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegTemp:   cal_q.temp     <= pwdata[47:0];
        RegPressL: cal_q.press_lo <= pwdata;
        RegPressH: cal_q.press_hi <= pwdata;
        RegP9Hum:  cal_q.p9_hum   <= pwdata[47:0];
        RegHumH:   cal_q.hum_hi   <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegTemp:   prdata = {16'b0, cal_q.temp};
      RegPressL: prdata = cal_q.press_lo;
      RegPressH: prdata = cal_q.press_hi;
      RegP9Hum:  prdata = {16'b0, cal_q.p9_hum};
      RegHumH:   prdata = {24'b0, cal_q.hum_hi};
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/srcmp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compensation front end
// Twelve stages: temperature, pressure numerator and divisor, and humidity.
// ----------------------------------------------------------------------------
module srcmp_front import srcmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  calib_t   cal_i,
  output div_req_t req_o
);

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;

  assign t1 = ux16(cal_i.temp[15:0]);
  assign t2 = sx16(cal_i.temp[31:16]);
  assign t3 = sx16(cal_i.temp[47:32]);
  assign p1 = ux16(cal_i.press_lo[15:0]);
  assign p2 = sx16(cal_i.press_lo[31:16]);
  assign p3 = sx16(cal_i.press_lo[47:32]);
  assign p4 = sx16(cal_i.press_lo[63:48]);
  assign p5 = sx16(cal_i.press_hi[15:0]);
  assign p6 = sx16(cal_i.press_hi[31:16]);
  assign h1 = ux8(cal_i.p9_hum[23:16]);
  assign h2 = sx16(cal_i.p9_hum[39:24]);
  assign h3 = ux8(cal_i.p9_hum[47:40]);
  assign h4 = sx16(cal_i.hum_hi[15:0]);
  assign h5 = sx16(cal_i.hum_hi[31:16]);
  assign h6 = sx8(cal_i.hum_hi[39:32]);

  logic [11:1] v_q;

  logic [31:0] s1_tam_q, s1_tdd_q;
  logic [19:0] s1_rp_q, s2_rp_q, s3_rp_q, s4_rp_q, s5_rp_q, s6_rp_q, s7_rp_q;
  logic [15:0] s1_rh_q, s2_rh_q, s3_rh_q, s4_rh_q, s5_rh_q;
  logic [31:0] s2_ta_q, s2_tbm_q, s3_tfine_q;
  logic [31:0] s4_tc_q, s4_pa_q, s4_pd_q, s4_x_q;
  logic [31:0] s5_sq_q, s5_pa5_q, s5_pa2_q, s5_hx5_q, s5_hx6_q, s5_hx3_q, s5_tc_q;
  logic [31:0] s6_b0_q, s6_p3m_q, s6_pa5_q, s6_pa2_q, s6_ha_q, s6_hb1_q, s6_tc_q;
  logic [31:0] s7_pb_q, s7_pas_q, s7_hb2_q, s7_ha_q, s7_tc_q;
  logic [31:0] s8_pdm_q, s8_pn0_q, s8_hb_q, s8_ha_q, s8_tc_q;
  logic [31:0] s9_div_q, s9_pnm_q, s9_hv_q, s9_tc_q;
  logic [31:0] s10_dvd_q, s10_div_q, s10_hdd_q, s10_hv_q, s10_tc_q;
  logic        s10_dbl_q, s10_err_q;
  logic [31:0] s11_dvd_q, s11_div_q, s11_hm_q, s11_hv_q, s11_tc_q;
  logic        s11_dbl_q, s11_err_q;
  logic        s12_v_q;
  logic [31:0] s12_dvd_q, s12_dvs_q;
  side_t       s12_side_q;

  logic [31:0] rt, s1_d, s4_pa_d, hv2, hcl;

  assign rt      = {12'b0, in_item_i.raw_temperature};
  assign s1_d    = (rt >> 4) - t1;
  assign s4_pa_d = asr32(s3_tfine_q, 1) - PressOffset;
  assign hv2     = s11_hv_q - asr32(s11_hm_q, 4);

  always_comb begin
    if (hv2[31]) begin
      hcl = '0;
    end else if (hv2 > HClamp) begin
      hcl = HClamp;
    end else begin
      hcl = hv2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      s12_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[10:1], in_valid_i};
      s12_v_q <= v_q[11];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Temperature.
      s1_tam_q <= mul32((rt >> 3) - (t1 << 1), t2);
      s1_tdd_q <= mul32(s1_d, s1_d);
      s1_rp_q  <= in_item_i.raw_pressure;
      s1_rh_q  <= in_item_i.raw_humidity;

      s2_ta_q  <= asr32(s1_tam_q, 11);
      s2_tbm_q <= mul32(asr32(s1_tdd_q, 12), t3);
      s2_rp_q  <= s1_rp_q;
      s2_rh_q  <= s1_rh_q;

      s3_tfine_q <= s2_ta_q + asr32(s2_tbm_q, 14);
      s3_rp_q    <= s2_rp_q;
      s3_rh_q    <= s2_rh_q;

      s4_tc_q <= asr32(mul32(s3_tfine_q, C5) + C128, 8);
      s4_pa_q <= s4_pa_d;
      s4_pd_q <= asr32(s4_pa_d, 2);
      s4_x_q  <= s3_tfine_q - HTempOffset;
      s4_rp_q <= s3_rp_q;
      s4_rh_q <= s3_rh_q;

      // Pressure and humidity products.
      s5_sq_q  <= mul32(s4_pd_q, s4_pd_q);
      s5_pa5_q <= mul32(s4_pa_q, p5);
      s5_pa2_q <= mul32(p2, s4_pa_q);
      s5_hx5_q <= mul32(h5, s4_x_q);
      s5_hx6_q <= mul32(s4_x_q, h6);
      s5_hx3_q <= mul32(s4_x_q, h3);
      s5_tc_q  <= s4_tc_q;
      s5_rp_q  <= s4_rp_q;
      s5_rh_q  <= s4_rh_q;

      s6_b0_q  <= mul32(asr32(s5_sq_q, 11), p6);
      s6_p3m_q <= mul32(p3, asr32(s5_sq_q, 13));
      s6_pa5_q <= s5_pa5_q;
      s6_pa2_q <= s5_pa2_q;
      s6_ha_q  <= asr32(({16'b0, s5_rh_q} << 14) - (h4 << 20) - s5_hx5_q + C16384, 15);
      s6_hb1_q <= mul32(asr32(s5_hx6_q, 10), asr32(s5_hx3_q, 11) + C32768);
      s6_tc_q  <= s5_tc_q;
      s6_rp_q  <= s5_rp_q;

      s7_pb_q  <= asr32(s6_b0_q + (s6_pa5_q << 1), 2) + (p4 << 16);
      s7_pas_q <= asr32(asr32(s6_p3m_q, 3) + asr32(s6_pa2_q, 1), 18);
      s7_hb2_q <= mul32(asr32(s6_hb1_q, 10) + HConstA, h2);
      s7_ha_q  <= s6_ha_q;
      s7_tc_q  <= s6_tc_q;
      s7_rp_q  <= s6_rp_q;

      s8_pdm_q <= mul32(C32768 + s7_pas_q, p1);
      s8_pn0_q <= (RawPFull - {12'b0, s7_rp_q}) - asr32(s7_pb_q, 12);
      s8_hb_q  <= asr32(s7_hb2_q + C8192, 14);
      s8_ha_q  <= s7_ha_q;
      s8_tc_q  <= s7_tc_q;

      s9_div_q <= asr32(s8_pdm_q, 15);
      s9_pnm_q <= mul32(s8_pn0_q, PScale);
      s9_hv_q  <= mul32(s8_ha_q, s8_hb_q);
      s9_tc_q  <= s8_tc_q;

      // Small numerators are doubled before the divide, large ones after.
      s10_dbl_q <= (s9_pnm_q >= PHalfRange);
      s10_dvd_q <= (s9_pnm_q < PHalfRange) ? (s9_pnm_q << 1) : s9_pnm_q;
      s10_div_q <= s9_div_q;
      s10_err_q <= (s9_div_q == '0);
      s10_hdd_q <= mul32(asr32(s9_hv_q, 15), asr32(s9_hv_q, 15));
      s10_hv_q  <= s9_hv_q;
      s10_tc_q  <= s9_tc_q;

      s11_hm_q  <= mul32(asr32(s10_hdd_q, 7), h1);
      s11_hv_q  <= s10_hv_q;
      s11_dvd_q <= s10_dvd_q;
      s11_div_q <= s10_div_q;
      s11_dbl_q <= s10_dbl_q;
      s11_err_q <= s10_err_q;
      s11_tc_q  <= s10_tc_q;

      s12_dvd_q      <= s11_dvd_q;
      s12_dvs_q      <= s11_div_q;
      s12_side_q.tc  <= s11_tc_q;
      s12_side_q.hum <= hcl[28:12];
      s12_side_q.err <= s11_err_q;
      s12_side_q.dbl <= s11_dbl_q;
    end
  end

  assign req_o = {s12_v_q, s12_dvd_q, s12_dvs_q, s12_side_q};

endmodule
`default_nettype wire

FILE: rtl/core/srcmp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, sideband carried along.
// ----------------------------------------------------------------------------
module srcmp_div import srcmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivW-1:0] rem_q [DivW];
  logic [DivW-1:0] dq_q  [DivW];
  logic [DivW-1:0] dvs_q [DivW];
  side_t           side_q [DivW];
  logic            v_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_st
    logic [DivW-1:0] rem_in, dq_in, dvs_in;
    side_t           side_in;
    logic            v_in;
    logic [DivW:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = req_i.dividend;
      assign dvs_in  = req_i.divisor;
      assign side_in = req_i.side;
      assign v_in    = req_i.valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dq_in   = dq_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign trial = {rem_in, dq_in[DivW-1]};
    assign take  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? DivW'(trial - {1'b0, dvs_in}) : trial[DivW-1:0];
        dq_q[k]   <= {dq_in[DivW-2:0], take};
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign rsp_o.valid    = v_q[DivW-1];
  assign rsp_o.quotient = dq_q[DivW-1];
  assign rsp_o.side     = side_q[DivW-1];

endmodule
`default_nettype wire

FILE: rtl/core/srcmp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure back end
// Second-order pressure correction and the output register.
// ----------------------------------------------------------------------------
module srcmp_back import srcmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  div_rsp_t  rsp_i,
  input  calib_t    cal_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic [31:0] p7, p8, p9, pq;
  logic [31:0] b1_p_q, b1_m1_q, b1_m2_q, b2_p_q, b2_m3_q, b2_bt_q;
  side_t       b1_side_q, b2_side_q;
  logic [2:0]  v_q;
  out_item_t   out_q;

  assign p7 = sx16(cal_i.press_hi[47:32]);
  assign p8 = sx16(cal_i.press_hi[63:48]);
  assign p9 = sx16(cal_i.p9_hum[15:0]);
  assign pq = rsp_i.side.dbl ? (rsp_i.quotient << 1) : rsp_i.quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], rsp_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_p_q    <= pq;
      b1_m1_q   <= mul32(pq >> 3, pq >> 3);
      b1_m2_q   <= mul32(pq >> 2, p8);
      b1_side_q <= rsp_i.side;

      b2_p_q    <= b1_p_q;
      b2_m3_q   <= mul32(p9, b1_m1_q >> 13);
      b2_bt_q   <= asr32(b1_m2_q, 13);
      b2_side_q <= b1_side_q;

      out_q.temperature_centi <= $signed(b2_side_q.tc);
      out_q.pressure_pa       <= b2_side_q.err ? '0 :
                                 b2_p_q + asr32(asr32(b2_m3_q, 12) + b2_bt_q + p7, 4);
      out_q.humidity_q10      <= b2_side_q.hum;
      out_q.divide_error      <= b2_side_q.err;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/sensor_reading_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor reading compensation
// Integer temperature, pressure and humidity compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: raw samples enter as one item on the in channel (valid/ready), and
// one compensated item leaves on the out channel for each input item, in order.
// Calibration coefficients are written through the APB-style port at byte
// address 8*i, only while no item is in flight: a user rule, not enforced.
// The pipeline has 47 register stages: 12 front-end stages, 32 divider
// stages (one quotient bit each) and 3 back-end stages, the last being the
// output register. Throughput is one item per cycle while the receiver does
// not stall; the 32-stage pressure divider sets the latency.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls with a result waiting, every stage
// holds, and in_ready_o drops until the output moves again. No item is lost
// or repeated. Reset empties the pipeline and clears all calibration registers.
// A zero pressure divisor gives pressure 0 with divide_error set.
// ----------------------------------------------------------------------------
module sensor_reading_compensation import srcmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic      pready,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  calib_t   cal;
  div_req_t req;
  div_rsp_t rsp;
  logic     en;

  // Pipeline advance: free whenever the output slot is empty or draining.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  srcmp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  srcmp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .cal_i      (cal),
    .req_o      (req)
  );

  srcmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  srcmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .rsp_i       (rsp),
    .cal_i       (cal),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
